FILE: hw/rtl/ghp_pkg.sv
// Shared widths, register indexes and the exponent fraction table of the heatmap pixel block.
`default_nettype none

package ghp_pkg;

  localparam int unsigned COORD_W    = 10;
  localparam int unsigned INV_VAR_W  = 24;
  localparam int unsigned HEAT_W     = 15;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_ROW  = 2'd0,
    REG_CENTER_COL  = 2'd1,
    REG_INV_TWO_VAR = 2'd2
  } cfg_reg_e;

  localparam logic [INV_VAR_W-1:0] INV_TWO_VAR_RESET = 24'd19022;

  localparam int unsigned EXP_TABLE_DEPTH = 64;
  localparam int unsigned EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);
  localparam int unsigned EXP_ADDR_W      = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int unsigned EXP_ENTRY_W     = 31;
  localparam int unsigned SERIES_TERMS    = 24;

  localparam logic [63:0] LN2_Q30  = 64'd744261118;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [63:0] Q30_ONE  = 64'd1 << 30;

  typedef logic [EXP_ENTRY_W-1:0] exp_entry_t;
  typedef exp_entry_t exp_tab_t [EXP_TABLE_DEPTH+1];

  // Entry i holds 2^-(i/EXP_TABLE_DEPTH) in Q.30 from a truncated Taylor series of exp(-z).
  function automatic exp_tab_t build_exp_table();
    exp_tab_t    tab;
    logic [63:0] z;
    logic [63:0] term;
    longint      sum;
    for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
      z    = (64'(i) * LN2_Q30 + 64'(EXP_TABLE_DEPTH / 2)) / EXP_TABLE_DEPTH;
      term = Q30_ONE;
      sum  = longint'(Q30_ONE);
      for (int n = 1; n <= SERIES_TERMS; n++) begin
        term = ((term * z) >> 30) / 64'(n);
        if ((n % 2) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        tab[i] = '0;
      end else begin
        tab[i] = EXP_ENTRY_W'(sum);
      end
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TABLE = build_exp_table();

endpackage

`default_nettype wire

FILE: hw/rtl/ghp_pix_if.sv
// Pixel coordinate channel of the heatmap pixel block.
`default_nettype none

interface ghp_pix_if;
  import ghp_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pixel_row;
  logic [COORD_W-1:0] pixel_col;

  modport source (output valid, output pixel_row, output pixel_col, input ready);
  modport sink   (input valid, input pixel_row, input pixel_col, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ghp_heat_if.sv
// Heatmap value channel of the heatmap pixel block.
`default_nettype none

interface ghp_heat_if;
  import ghp_pkg::*;

  logic              valid;
  logic              ready;
  logic [HEAT_W-1:0] heat_value;

  modport source (output valid, output heat_value, input ready);
  modport sink   (input valid, input heat_value, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ghp_cfg_if.sv
// Register write channel of the heatmap pixel block.
`default_nettype none

interface ghp_cfg_if;
  import ghp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/gaussian_heatmap_pixel_top.sv
// Top level of the Gaussian keypoint heatmap pixel pipeline.
// One pixel beat is taken every clock unless heat_o.ready stalls the pipeline.
// The pipeline has nine register stages, each with at most one multiply in depth.
// Reset empties the pipeline and sets the center to row 0, column 0 and inv_two_var
// to 19022 (sigma 21). Register writes take effect at once and are always accepted.
`default_nettype none

module gaussian_heatmap_pixel_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  ghp_pix_if.sink     pix_i,
  ghp_cfg_if.sink     cfg_i,
  ghp_heat_if.source  heat_o
);
  import ghp_pkg::*;

  localparam int unsigned NSTAGE = 9;
  localparam int unsigned D2_W   = 2 * COORD_W + 1;
  localparam int unsigned T_W    = D2_W + INV_VAR_W;
  localparam int unsigned TL_W   = 29;
  localparam int unsigned YP_W   = TL_W + 31;
  localparam int unsigned Y_W    = 29;
  localparam int unsigned K_W    = 5;
  localparam int unsigned FR_W   = 24;
  localparam int unsigned PR_W   = EXP_ENTRY_W + FR_W;
  localparam int unsigned X_W    = EXP_ENTRY_W + 7;
  localparam logic [T_W-1:0] FLUSH_LIMIT = T_W'(1) << 28;

  logic [COORD_W-1:0]   center_row_q;
  logic [COORD_W-1:0]   center_col_q;
  logic [INV_VAR_W-1:0] inv_two_var_q;

  logic [NSTAGE-1:0] valid_q;
  logic [NSTAGE-1:0] adv;

  logic [COORD_W-1:0] dr_d, dc_d, dr_q, dc_q;
  logic [2*COORD_W-1:0] sq_r, sq_c;
  logic [D2_W-1:0] d2_q;
  logic [T_W-1:0] t_q;
  logic [YP_W-1:0] y_sum;
  logic [Y_W-1:0] y_q;
  logic flush3_q;

  logic [EXP_IDX_W-1:0]  tab_idx;
  logic [EXP_ADDR_W-1:0] addr_a, addr_b;
  exp_entry_t            ent_a, ent_b;
  exp_entry_t            a4_q, diff4_q, a5_q, v_d, v_q;
  logic [FR_W-1:0]       w4_q;
  logic [K_W-1:0]        k4_q, k5_q, k6_q, k7_q;
  logic                  flush4_q, flush5_q, flush6_q, flush7_q;
  logic [PR_W-1:0]       prod_q;
  logic [PR_W:0]         rnd_sum;
  logic [X_W-1:0]        x_q;
  logic [5:0]            shamt;
  logic [X_W-1:0]        q_shift;
  logic [X_W:0]          q_inc;
  logic [HEAT_W-1:0]     heat_d, heat_q;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_row_q  <= '0;
      center_col_q  <= '0;
      inv_two_var_q <= INV_TWO_VAR_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_CENTER_ROW:  center_row_q  <= cfg_i.data[COORD_W-1:0];
        REG_CENTER_COL:  center_col_q  <= cfg_i.data[COORD_W-1:0];
        REG_INV_TWO_VAR: inv_two_var_q <= cfg_i.data[INV_VAR_W-1:0];
        default: ;
      endcase
    end
  end

  // A stage moves on when it is empty or when the stage after it moves.
  always_comb begin
    adv[NSTAGE-1] = !valid_q[NSTAGE-1] || heat_o.ready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      adv[i] = !valid_q[i] || adv[i+1];
    end
  end

  assign pix_i.ready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) begin
        valid_q[0] <= pix_i.valid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (adv[i]) begin
          valid_q[i] <= valid_q[i-1];
        end
      end
    end
  end

  // Absolute coordinate differences.
  assign dr_d = (pix_i.pixel_row >= center_row_q) ? pix_i.pixel_row - center_row_q
                                                  : center_row_q - pix_i.pixel_row;
  assign dc_d = (pix_i.pixel_col >= center_col_q) ? pix_i.pixel_col - center_col_q
                                                  : center_col_q - pix_i.pixel_col;

  assign sq_r = (2*COORD_W)'(dr_q) * (2*COORD_W)'(dr_q);
  assign sq_c = (2*COORD_W)'(dc_q) * (2*COORD_W)'(dc_q);

  assign y_sum = YP_W'(t_q[TL_W-1:0]) * YP_W'(LOG2E_Q30) + (YP_W'(1) << 29);

  // Table lookup on the top bits of the fraction, interpolation weight from the rest.
  assign tab_idx = y_q[FR_W-1 -: EXP_IDX_W];
  assign addr_a  = EXP_ADDR_W'(tab_idx);
  assign addr_b  = addr_a + EXP_ADDR_W'(1);
  assign ent_a   = EXP_TABLE[addr_a];
  assign ent_b   = EXP_TABLE[addr_b];

  assign rnd_sum = (PR_W+1)'(prod_q) + ((PR_W+1)'(1) << 23);
  assign v_d     = a5_q - EXP_ENTRY_W'(rnd_sum >> 24);

  assign shamt   = 6'(k7_q) + 6'd21;
  assign q_shift = x_q >> shamt;
  assign q_inc   = (X_W+1)'(q_shift) + (X_W+1)'(1);
  assign heat_d  = flush7_q ? '0 : HEAT_W'(q_inc >> 1);

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      dr_q <= dr_d;
      dc_q <= dc_d;
    end
    if (adv[1]) begin
      d2_q <= D2_W'(sq_r) + D2_W'(sq_c);
    end
    if (adv[2]) begin
      t_q <= T_W'(d2_q) * T_W'(inv_two_var_q);
    end
    if (adv[3]) begin
      y_q      <= y_sum[Y_W+29:30];
      flush3_q <= t_q > FLUSH_LIMIT;
    end
    if (adv[4]) begin
      a4_q     <= ent_a;
      diff4_q  <= (ent_a > ent_b) ? ent_a - ent_b : '0;
      w4_q     <= {y_q[FR_W-EXP_IDX_W-1:0], EXP_IDX_W'(0)};
      k4_q     <= y_q[Y_W-1:FR_W];
      flush4_q <= flush3_q;
    end
    if (adv[5]) begin
      prod_q   <= PR_W'(diff4_q) * PR_W'(w4_q);
      a5_q     <= a4_q;
      k5_q     <= k4_q;
      flush5_q <= flush4_q;
    end
    if (adv[6]) begin
      v_q      <= v_d;
      k6_q     <= k5_q;
      flush6_q <= flush5_q;
    end
    if (adv[7]) begin
      x_q      <= X_W'(v_q) * X_W'(100);
      k7_q     <= k6_q;
      flush7_q <= flush6_q;
    end
    if (adv[8]) begin
      heat_q <= heat_d;
    end
  end

  assign heat_o.valid      = valid_q[NSTAGE-1];
  assign heat_o.heat_value = heat_q;

endmodule

`default_nettype wire

FILE: tb/sv/gaussian_heatmap_pixel_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the Gaussian heatmap pixel block with its own heat value predictor.
module gaussian_heatmap_pixel_top_tb;
  import ghp_pkg::*;

  localparam int unsigned FRAC_STEPS = 64;
  localparam int unsigned TAYLOR_TERMS = 24;
  localparam logic [63:0] LN2_FX = 64'd744261118;
  localparam logic [63:0] LOG2E_FX = 64'd1549082005;
  localparam logic [63:0] FRAC24_MASK = 64'hFF_FFFF;
  localparam logic [63:0] T_FLUSH = 64'd16 << 24;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [CFG_DATA_W-1:0] INV_MAX = 24'hFF_FFFF;
  localparam logic [CFG_DATA_W-1:0] INV_ONE = 24'd1;
  localparam logic [CFG_DATA_W-1:0] INV_ZERO = 24'd0;
  localparam logic [CFG_DATA_W-1:0] INV_FLUSH_EDGE = 24'h10_0000;
  localparam int unsigned PIPE_DRAIN = 20;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned REPORT_MAX = 10;
  localparam int unsigned SWEEP_PHASES = 6;
  localparam int unsigned SWEEP_PIXELS = 110;

  logic clk_i = 1'b0;
  logic rst_ni;

  ghp_pix_if  pix_bus ();
  ghp_cfg_if  cfg_bus ();
  ghp_heat_if heat_bus ();

  gaussian_heatmap_pixel_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_bus),
    .cfg_i  (cfg_bus),
    .heat_o (heat_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [COORD_W-1:0]   ctr_row;
  logic [COORD_W-1:0]   ctr_col;
  logic [INV_VAR_W-1:0] inv_var;
  logic [63:0]          pow2_frac_q30 [FRAC_STEPS+1];
  logic [HEAT_W-1:0]    pending_heat [$];

  bit src_idle;
  bit sink_idle;
  bit sink_hold = 1'b0;

  int unsigned mismatch_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned pixels_sent = 0;
  int unsigned cfg_writes = 0;
  int unsigned cycle_cnt = 0;

  // 2^-(i/64) in Q.30 from a truncated Taylor series of exp(-i*ln2/64).
  function automatic logic [63:0] exp2_neg_frac(int unsigned i);
    logic [63:0] z;
    logic [63:0] term;
    longint      acc;
    z    = (64'(i) * LN2_FX + 64'(FRAC_STEPS / 2)) / 64'(FRAC_STEPS);
    term = 64'd1 << 30;
    acc  = longint'(term);
    for (int unsigned n = 1; n <= TAYLOR_TERMS; n++) begin
      term = ((term * z) >> 30) / 64'(n);
      if ((n % 2) == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    return (acc < 0) ? 64'd0 : 64'(acc);
  endfunction

  function automatic logic [HEAT_W-1:0] gaussian_heat(logic [COORD_W-1:0] row,
                                                      logic [COORD_W-1:0] col);
    logic [63:0] dr, dc, t, y, k, f, p, w, a, b, diff, v, s;
    int unsigned idx;
    dr = (row >= ctr_row) ? 64'(row - ctr_row) : 64'(ctr_row - row);
    dc = (col >= ctr_col) ? 64'(col - ctr_col) : 64'(ctr_col - col);
    t  = (dr * dr + dc * dc) * 64'(inv_var);
    if (t > T_FLUSH) begin
      return '0;
    end
    y    = (t * LOG2E_FX + (64'd1 << 29)) >> 30;
    k    = y >> 24;
    f    = y & FRAC24_MASK;
    p    = f * 64'(FRAC_STEPS);
    idx  = int'(p >> 24);
    w    = p & FRAC24_MASK;
    a    = pow2_frac_q30[idx];
    b    = pow2_frac_q30[idx+1];
    diff = (a > b) ? a - b : 64'd0;
    v    = a - ((diff * w + (64'd1 << 23)) >> 24);
    s    = 64'd22 + k;
    return HEAT_W'((64'd100 * v + (64'd1 << (s - 1))) >> s);
  endfunction

  task automatic send_pixel(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      pix_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_bus.valid     <= 1'b1;
    pix_bus.pixel_row <= row;
    pix_bus.pixel_col <= col;
    do begin
      @(posedge clk_i);
    end while (!pix_bus.ready);
    pending_heat = {pending_heat, gaussian_heat(row, col)};
    pixels_sent++;
  endtask

  task automatic wait_heat_drained();
    pix_bus.valid <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (pending_heat.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do begin
      @(posedge clk_i);
    end while (!cfg_bus.ready);
    case (idx)
      REG_CENTER_ROW:  ctr_row = data[COORD_W-1:0];
      REG_CENTER_COL:  ctr_col = data[COORD_W-1:0];
      REG_INV_TWO_VAR: inv_var = data[INV_VAR_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // The bits above the coordinate are random so that the block must drop them.
  task automatic set_center(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col);
    write_reg(REG_CENTER_ROW, {14'($urandom()), row});
    write_reg(REG_CENTER_COL, {14'($urandom()), col});
  endtask

  task automatic report_heat_error(input bit has_want, input logic [HEAT_W-1:0] want,
                                   input logic [HEAT_W-1:0] got);
    if (mismatch_cnt < REPORT_MAX) begin
      if (has_want) begin
        $display("heat_value mismatch: expected %0d, got %0d", want, got);
      end else begin
        $display("heat beat %0d arrived with no pixel pending", got);
      end
    end
    mismatch_cnt++;
  endtask

  initial begin : heat_sink
    int unsigned       stall;
    logic [HEAT_W-1:0] want;
    stall = 0;
    heat_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (heat_bus.valid && heat_bus.ready) begin
        stall = sink_idle ? $urandom_range(0, 3) : 0;
        if (pending_heat.size() == 0) begin
          report_heat_error(1'b0, '0, heat_bus.heat_value);
        end else begin
          want = pending_heat.pop_front();
          checked_cnt++;
          if (want !== heat_bus.heat_value) begin
            report_heat_error(1'b1, want, heat_bus.heat_value);
          end
        end
      end
      if (sink_hold) begin
        heat_bus.ready <= 1'b0;
      end else if (stall != 0) begin
        stall--;
        heat_bus.ready <= 1'b0;
      end else begin
        heat_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("gaussian_heatmap_pixel_top_tb NOT OK");
      $finish;
    end
  end

  task automatic test_reset_config();
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd21, 10'd0);
    send_pixel(10'd0, 10'd21);
    send_pixel(10'd15, 10'd15);
    send_pixel(10'd767, 10'd1023);
    send_pixel(10'd1023, 10'd1023);
    wait_heat_drained();
  endtask

  task automatic test_center_extremes();
    write_reg(REG_CENTER_ROW, INV_MAX);
    write_reg(REG_CENTER_COL, INV_MAX);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd1000, 10'd1010);
    send_pixel(10'd0, 10'd0);
    wait_heat_drained();
    write_reg(REG_CENTER_ROW, 24'hFF_FC00);
    write_reg(REG_CENTER_COL, 24'h00_03FF);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd5, 10'd1020);
    wait_heat_drained();
  endtask

  // With 2^-4 per unit of squared distance, a distance of 16 lands exactly on the flush limit.
  task automatic test_flush_edge();
    set_center(10'd100, 10'd200);
    write_reg(REG_INV_TWO_VAR, INV_FLUSH_EDGE);
    send_pixel(10'd116, 10'd200);
    send_pixel(10'd116, 10'd201);
    send_pixel(10'd84, 10'd200);
    send_pixel(10'd100, 10'd184);
    send_pixel(10'd101, 10'd201);
    wait_heat_drained();
  endtask

  task automatic test_variance_extremes();
    write_reg(REG_INV_TWO_VAR, INV_ZERO);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    wait_heat_drained();
    write_reg(REG_INV_TWO_VAR, INV_MAX);
    send_pixel(10'd101, 10'd200);
    send_pixel(10'd104, 10'd200);
    send_pixel(10'd104, 10'd201);
    wait_heat_drained();
    write_reg(REG_INV_TWO_VAR, INV_ONE);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd0);
    wait_heat_drained();
  endtask

  task automatic test_unused_index();
    write_reg(REG_UNUSED, INV_MAX);
    send_pixel(10'd100, 10'd200);
    send_pixel(10'd110, 10'd205);
    wait_heat_drained();
  endtask

  task automatic test_random_sweep();
    int unsigned          sigma;
    int unsigned          radius;
    logic [INV_VAR_W-1:0] inv;
    logic [COORD_W-1:0]   row;
    logic [COORD_W-1:0]   col;
    for (int unsigned phase = 0; phase < SWEEP_PHASES; phase++) begin
      src_idle  = (phase % 4 == 0) || (phase % 4 == 2);
      sink_idle = (phase % 4 == 0) || (phase % 4 == 3);
      case (phase)
        1: begin
          inv    = INV_MAX;
          radius = 8;
          set_center(10'd0, 10'd1023);
        end
        3: begin
          inv    = INV_ONE;
          radius = 1023;
          set_center(10'd1023, 10'd0);
        end
        5: begin
          inv    = INV_TWO_VAR_RESET;
          radius = 130;
          set_center(COORD_W'($urandom()), COORD_W'($urandom()));
        end
        default: begin
          sigma  = $urandom_range(1, 150);
          inv    = INV_VAR_W'(((64'd1 << 24) + 64'(sigma * sigma)) / 64'(2 * sigma * sigma));
          radius = (6 * sigma + 2 > 1023) ? 1023 : 6 * sigma + 2;
          set_center(COORD_W'($urandom()), COORD_W'($urandom()));
        end
      endcase
      write_reg(REG_INV_TWO_VAR, inv);
      for (int unsigned n = 0; n < SWEEP_PIXELS; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          row = COORD_W'($urandom());
          col = COORD_W'($urandom());
        end else begin
          row = COORD_W'(32'(ctr_row) + $urandom_range(0, 2 * radius) - radius);
          col = COORD_W'(32'(ctr_col) + $urandom_range(0, 2 * radius) - radius);
        end
        send_pixel(row, col);
      end
      wait_heat_drained();
    end
  endtask

  // The output side stays blocked long enough for the pipeline to fill and push back.
  task automatic test_output_stall();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    set_center(10'd400, 10'd500);
    write_reg(REG_INV_TWO_VAR, INV_TWO_VAR_RESET);
    fork
      begin
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        sink_hold <= 1'b0;
      end
    join_none
    for (int unsigned n = 0; n < 40; n++) begin
      send_pixel(COORD_W'(10'd400 + $urandom_range(0, 160) - 80),
                 COORD_W'(10'd500 + $urandom_range(0, 160) - 80));
    end
    wait_heat_drained();
  endtask

  initial begin
    for (int unsigned i = 0; i <= FRAC_STEPS; i++) begin
      pow2_frac_q30[i] = exp2_neg_frac(i);
    end
    ctr_row   = '0;
    ctr_col   = '0;
    inv_var   = INV_TWO_VAR_RESET;
    src_idle  = 1'b1;
    sink_idle = 1'b1;

    rst_ni            <= 1'b0;
    pix_bus.valid     <= 1'b0;
    pix_bus.pixel_row <= '0;
    pix_bus.pixel_col <= '0;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.index     <= REG_CENTER_ROW;
    cfg_bus.data      <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_config();
    test_center_extremes();
    test_flush_edge();
    test_variance_extremes();
    test_unused_index();
    test_random_sweep();
    test_output_stall();

    repeat (PIPE_DRAIN) @(posedge clk_i);
    $display("Checked %0d heat values from %0d pixels over %0d register writes,", checked_cnt,
             pixels_sent, cfg_writes);
    $display("covering reset, extreme centers and variances, the flush edge and a long stall.");
    if (mismatch_cnt == 0 && pending_heat.size() == 0) begin
      $display("gaussian_heatmap_pixel_top_tb OK");
    end else begin
      $display("gaussian_heatmap_pixel_top_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: gaussian_heatmap_pixel_top.f
hw/rtl/ghp_pkg.sv
hw/rtl/ghp_pix_if.sv
hw/rtl/ghp_heat_if.sv
hw/rtl/ghp_cfg_if.sv
hw/rtl/gaussian_heatmap_pixel_top.sv
tb/sv/gaussian_heatmap_pixel_top_tb.sv
